[hw/rtl/clod_pkg.sv]
// ----------------------------------------------------------------------------
// clod_pkg
// Shared constants and types for the chunk LOD distance core.
// ----------------------------------------------------------------------------
package clod_pkg;

    localparam int COORD_BITS_DEF    = 24;
    localparam int LOD_FRAC_BITS_DEF = 8;

    localparam int TD_W    = 9;
    localparam int DMAX_W  = 23;
    localparam int OUT_W   = 16;
    localparam int Q_SHIFT = 30;
    localparam int XW      = 31;

    localparam logic [TD_W-1:0]   TD_RESET   = 9'd8;
    localparam logic [DMAX_W-1:0] DMAX_RESET = 23'd256;

    typedef enum logic [0:0] {
        CFG_TREE_DEPTH = 1'b0,
        CFG_LOD_DMAX   = 1'b1
    } t_cfg_idx;

endpackage

[hw/rtl/clod_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// clod_sqrt_cell
// One step of the integer square root: settles one bit of the root.
// ----------------------------------------------------------------------------
module clod_sqrt_cell #(
    parameter int SW = 52
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SW/2+1:0]   i_rem,
    input  logic [SW/2-1:0]   i_root,
    input  logic [SW-1:0]     i_rad,
    output logic              o_valid,
    output logic [SW/2+1:0]   o_rem,
    output logic [SW/2-1:0]   o_root,
    output logic [SW-1:0]     o_rad
);
    localparam int RW = SW / 2;

    logic [RW+3:0] w_rem;
    logic [RW+3:0] w_trial;
    logic [RW+1:0] n_rem;
    logic [RW-1:0] n_root;

    always_comb begin
        w_rem   = {i_rem, i_rad[SW-1 -: 2]};
        w_trial = (RW+4)'({i_root, 2'b01});
        if (w_rem >= w_trial) begin
            n_rem  = (RW+2)'(w_rem - w_trial);
            n_root = {i_root[RW-2:0], 1'b1};
        end else begin
            n_rem  = w_rem[RW+1:0];
            n_root = {i_root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_rem  <= n_rem;
        o_root <= n_root;
        o_rad  <= {i_rad[SW-3:0], 2'b00};
    end

endmodule

[hw/rtl/clod_div_cell.sv]
// ----------------------------------------------------------------------------
// clod_div_cell
// One restoring division step: shifts in a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module clod_div_cell #(
    parameter int DW = 56
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [clod_pkg::DMAX_W-1:0]   i_den,
    input  logic [clod_pkg::DMAX_W-1:0]   i_rem,
    input  logic [DW-1:0]                 i_nq,
    output logic                          o_valid,
    output logic [clod_pkg::DMAX_W-1:0]   o_rem,
    output logic [DW-1:0]                 o_nq
);
    import clod_pkg::*;

    logic [DMAX_W:0]   w_t;
    logic [DMAX_W-1:0] n_rem;
    logic              w_bit;

    always_comb begin
        w_t   = {i_rem, i_nq[DW-1]};
        w_bit = (w_t >= {1'b0, i_den});
        if (w_bit) begin
            n_rem = DMAX_W'(w_t - {1'b0, i_den});
        end else begin
            n_rem = w_t[DMAX_W-1:0];
        end
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_rem <= n_rem;
        o_nq  <= {i_nq[DW-2:0], w_bit};
    end

endmodule

[hw/rtl/clod_norm_cell.sv]
// ----------------------------------------------------------------------------
// clod_norm_cell
// One stage of the leading-zero normaliser: a fixed shift taken or not.
// ----------------------------------------------------------------------------
module clod_norm_cell #(
    parameter int W   = 56,
    parameter int LZW = 6,
    parameter int SH  = 32,
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [W-1:0]   i_val,
    input  logic [LZW-1:0] i_lz,
    input  logic [SBW-1:0] i_side,
    output logic           o_valid,
    output logic [W-1:0]   o_val,
    output logic [LZW-1:0] o_lz,
    output logic [SBW-1:0] o_side
);
    logic w_zero;

    assign w_zero = (i_val[W-1 -: SH] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_val  <= w_zero ? (i_val << SH) : i_val;
        o_lz   <= w_zero ? (i_lz + LZW'(SH)) : i_lz;
        o_side <= i_side;
    end

endmodule

[hw/rtl/clod_log_cell.sv]
// ----------------------------------------------------------------------------
// clod_log_cell
// One fraction bit of log2 by repeated squaring of a Q1.30 mantissa.
// ----------------------------------------------------------------------------
module clod_log_cell #(
    parameter int FW  = 8,
    parameter int SBW = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [clod_pkg::XW-1:0]   i_x,
    input  logic [FW-1:0]             i_frac,
    input  logic [SBW-1:0]            i_side,
    output logic                      o_valid,
    output logic [clod_pkg::XW-1:0]   o_x,
    output logic [FW-1:0]             o_frac,
    output logic [SBW-1:0]            o_side
);
    import clod_pkg::*;

    logic [2*XW-1:0] w_sq;
    logic [XW:0]     w_y;

    assign w_sq = i_x * i_x;
    assign w_y  = w_sq[Q_SHIFT +: XW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        // A square of two or more sets the bit and halves the mantissa.
        o_x    <= w_y[XW] ? w_y[XW:1] : w_y[XW-1:0];
        o_frac <= {i_frac[FW-2:0], w_y[XW]};
        o_side <= i_side;
    end

endmodule

[hw/rtl/chunk_lod_from_box_distance_core.sv]
// ----------------------------------------------------------------------------
// chunk_lod_from_box_distance_core
// Level of detail from the distance between a viewpoint and a box.
// ----------------------------------------------------------------------------
// Takes one query per clock: start is accepted whenever it is high, busy is
// always low. Each item gives its lod_level with an o_valid strobe after the
// gap, square and sum registers, the square root chain (R = gap width + 1),
// the divider chain (D = R + 30), the normaliser (S = clog2(D)), the log
// chain and the output register. The strobe lasts one cycle and cannot be
// held off. Write configuration only while no item is in flight.
module chunk_lod_from_box_distance_core #(
    parameter int COORD_BITS    = clod_pkg::COORD_BITS_DEF,
    parameter int LOD_FRAC_BITS = clod_pkg::LOD_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_BITS-1:0]       i_view_x,
    input  logic signed [COORD_BITS-1:0]       i_view_y,
    input  logic signed [COORD_BITS-1:0]       i_view_z,
    input  logic signed [COORD_BITS-1:0]       i_box_center_x,
    input  logic signed [COORD_BITS-1:0]       i_box_center_y,
    input  logic signed [COORD_BITS-1:0]       i_box_center_z,
    input  logic [COORD_BITS-2:0]              i_half_extent_x,
    input  logic [COORD_BITS-2:0]              i_half_extent_y,
    input  logic [COORD_BITS-2:0]              i_half_extent_z,
    input  logic                               i_cfg_we,
    input  clod_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [clod_pkg::DMAX_W-1:0]        i_cfg_data,
    output logic                               o_valid,
    output logic [clod_pkg::OUT_W-1:0]         o_lod_level
);
    import clod_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int F   = LOD_FRAC_BITS;
    localparam int GW  = (CB + 1 > 31) ? 31 : CB + 1;
    localparam int SW  = 2 * GW + 2;
    localparam int RW  = SW / 2;
    localparam int DW  = RW + Q_SHIFT;
    localparam int S   = $clog2(DW);
    localparam int EW  = TD_W + F + 2;
    localparam int LAT = 4 + RW + DW + S + F;
    localparam logic [CB:0] GAP_MAX = {(CB+1){1'b1}} >> (CB + 1 - GW);

    // Configuration
    logic [TD_W-1:0]   r_tree_depth;
    logic [DMAX_W-1:0] r_dmax;
    logic [DMAX_W-1:0] w_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_depth <= TD_RESET;
            r_dmax       <= DMAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TREE_DEPTH: r_tree_depth <= i_cfg_data[TD_W-1:0];
                CFG_LOD_DMAX:   r_dmax       <= i_cfg_data;
            endcase
        end
    end

    assign w_den = (r_dmax == '0) ? DMAX_W'(1) : r_dmax;
    assign busy  = 1'b0;

    // Per-axis gap, squares and sum
    logic signed [CB-1:0] w_v [3];
    logic signed [CB-1:0] w_c [3];
    logic [CB-2:0]        w_e [3];
    logic [GW-1:0]        r_gap [3];
    logic [2*GW-1:0]      r_sq [3];
    logic [SW-1:0]        r_sum;
    logic                 r_v_gap, r_v_sq, r_v_sum;

    assign w_v = '{i_view_x, i_view_y, i_view_z};
    assign w_c = '{i_box_center_x, i_box_center_y, i_box_center_z};
    assign w_e = '{i_half_extent_x, i_half_extent_y, i_half_extent_z};

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [CB:0] w_d;
        logic [CB:0]        w_abs;
        logic [CB:0]        w_g;

        assign w_d   = {w_v[a][CB-1], w_v[a]} - {w_c[a][CB-1], w_c[a]};
        assign w_abs = w_d[CB] ? (CB+1)'(-w_d) : w_d;
        assign w_g   = (w_abs > {2'b00, w_e[a]}) ? (w_abs - {2'b00, w_e[a]}) : '0;

        always_ff @(posedge i_clk) begin
            r_gap[a] <= (w_g > GAP_MAX) ? GAP_MAX[GW-1:0] : w_g[GW-1:0];
            r_sq[a]  <= r_gap[a] * r_gap[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_gap <= 1'b0;
            r_v_sq  <= 1'b0;
            r_v_sum <= 1'b0;
        end else begin
            r_v_gap <= start && !busy;
            r_v_sq  <= r_v_gap;
            r_v_sum <= r_v_sq;
        end
        r_sum <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    end

    // Square root chain
    logic          w_sq_v    [RW+1];
    logic [RW+1:0] w_sq_rem  [RW+1];
    logic [RW-1:0] w_sq_root [RW+1];
    logic [SW-1:0] w_sq_rad  [RW+1];

    assign w_sq_v[0]    = r_v_sum;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_rad[0]  = r_sum;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        clod_sqrt_cell #(.SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sq_v[k]),
            .i_rem   (w_sq_rem[k]),
            .i_root  (w_sq_root[k]),
            .i_rad   (w_sq_rad[k]),
            .o_valid (w_sq_v[k+1]),
            .o_rem   (w_sq_rem[k+1]),
            .o_root  (w_sq_root[k+1]),
            .o_rad   (w_sq_rad[k+1])
        );
    end

    // Divider chain: dist * 2^30 / distance_lod_max
    logic              w_dv_v   [DW+1];
    logic [DMAX_W-1:0] w_dv_rem [DW+1];
    logic [DW-1:0]     w_dv_nq  [DW+1];

    assign w_dv_v[0]   = w_sq_v[RW];
    assign w_dv_rem[0] = '0;
    assign w_dv_nq[0]  = {w_sq_root[RW], {Q_SHIFT{1'b0}}};

    for (genvar k = 0; k < DW; k++) begin : g_div
        clod_div_cell #(.DW(DW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv_v[k]),
            .i_den   (w_den),
            .i_rem   (w_dv_rem[k]),
            .i_nq    (w_dv_nq[k]),
            .o_valid (w_dv_v[k+1]),
            .o_rem   (w_dv_rem[k+1]),
            .o_nq    (w_dv_nq[k+1])
        );
    end

    // Normaliser chain; the side bit marks a ratio of one or less.
    logic          w_nm_v    [S+1];
    logic [DW-1:0] w_nm_val  [S+1];
    logic [S-1:0]  w_nm_lz   [S+1];
    logic [0:0]    w_nm_side [S+1];

    assign w_nm_v[0]    = w_dv_v[DW];
    assign w_nm_val[0]  = w_dv_nq[DW];
    assign w_nm_lz[0]   = '0;
    assign w_nm_side[0] = (w_dv_nq[DW] <= (DW'(1) << Q_SHIFT));

    for (genvar k = 0; k < S; k++) begin : g_norm
        clod_norm_cell #(.W(DW), .LZW(S), .SH(2 ** (S - 1 - k)), .SBW(1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_nm_v[k]),
            .i_val   (w_nm_val[k]),
            .i_lz    (w_nm_lz[k]),
            .i_side  (w_nm_side[k]),
            .o_valid (w_nm_v[k+1]),
            .o_val   (w_nm_val[k+1]),
            .o_lz    (w_nm_lz[k+1]),
            .o_side  (w_nm_side[k+1])
        );
    end

    // Log chain; side band carries {unity flag, integer part}.
    logic          w_lg_v    [F+1];
    logic [XW-1:0] w_lg_x    [F+1];
    logic [F-1:0]  w_lg_frac [F+1];
    logic [S:0]    w_lg_side [F+1];

    assign w_lg_v[0]    = w_nm_v[S];
    assign w_lg_x[0]    = w_nm_val[S][DW-1 -: XW];
    assign w_lg_frac[0] = '0;
    assign w_lg_side[0] = {w_nm_side[S], S'(DW - 1 - Q_SHIFT) - w_nm_lz[S]};

    for (genvar k = 0; k < F; k++) begin : g_log
        clod_log_cell #(.FW(F), .SBW(S + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_lg_v[k]),
            .i_x     (w_lg_x[k]),
            .i_frac  (w_lg_frac[k]),
            .i_side  (w_lg_side[k]),
            .o_valid (w_lg_v[k+1]),
            .o_x     (w_lg_x[k+1]),
            .o_frac  (w_lg_frac[k+1]),
            .o_side  (w_lg_side[k+1])
        );
    end

    // Final subtract and clamp
    logic [EW-1:0] w_td;
    logic [EW-1:0] w_l;
    logic [EW-1:0] w_lod;
    logic [OUT_W-1:0] n_lod;

    always_comb begin
        w_td  = EW'(r_tree_depth) << F;
        w_l   = w_lg_side[F][S] ? '0 : EW'({w_lg_side[F][S-1:0], w_lg_frac[F]});
        w_lod = w_td - EW'(1) - w_l;
        if (w_lod[EW-1]) begin
            n_lod = '0;
        end else if (w_lod > EW'({OUT_W{1'b1}})) begin
            n_lod = '1;
        end else begin
            n_lod = w_lod[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_lg_v[F];
        end
        o_lod_level <= n_lod;
    end

    // Checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted item produced no result at the pipeline latency");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, LAT)) |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted item");

    a_depth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_tree_depth == '0) |-> (o_lod_level == '0))
        else $error("zero tree depth must give level zero");

endmodule
